/* hw/rtl/tcl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Target change limiter package
// Shared constants, register indexes and list control type.
// ----------------------------------------------------------------------------
package tcl_pkg;

  // Default sizes of the two recent-id lists and of a stored id.
  localparam int unsigned TARGET_DEPTH_DEF = 16;
  localparam int unsigned REPLY_DEPTH_DEF  = 8;
  localparam int unsigned ID_WIDTH_DEF     = 32;

  // Fixed field widths of the ports.
  localparam int unsigned FIELD_ID_W  = 32;
  localparam int unsigned FIELD_NOW_W = 32;
  localparam int unsigned MT_W        = 5;
  localparam int unsigned MR_W        = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TARGETS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPLIES = 1'd1;

  // Register reset values.
  localparam logic [MT_W-1:0] MAX_TARGETS_RST = 5'd10;
  localparam logic [MR_W-1:0] MAX_REPLIES_RST = 4'd5;

  // One target slot is freed for every whole aging period.
  localparam logic [FIELD_NOW_W-1:0] AGING_PERIOD = 32'd60;

  // Input word kinds.
  localparam logic KIND_SEND  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // List update command: shift entries back up to the index and refill
  // the front either from the new id or from the entry at the index.
  typedef struct packed {
    logic shift;
    logic take_new;
  } tcl_op_t;

endpackage : tcl_pkg
`default_nettype wire

/* hw/rtl/tcl_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Target change limiter channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface tcl_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] target_id;
  logic [31:0] now_seconds;

  modport source (output valid, output kind, output target_id, output now_seconds,
                  input ready);
  modport sink   (input valid, input kind, input target_id, input now_seconds,
                  output ready);
endinterface : tcl_in_if

interface tcl_out_if;
  logic valid;
  logic ready;
  logic allowed;

  modport source (output valid, output allowed, input ready);
  modport sink   (input valid, input allowed, output ready);
endinterface : tcl_out_if
`default_nettype wire

/* hw/rtl/tcl_mru_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Most-recently-used id list
// Entry store with one read port and a shift-to-front update.
// ----------------------------------------------------------------------------
module tcl_mru_list #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ID_W  = 32,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire tcl_pkg::tcl_op_t op_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [ID_W-1:0]  new_id_i,
  output logic      [ID_W-1:0]  rd_data_o
);
  import tcl_pkg::*;

  logic [ID_W-1:0] ent_q [DEPTH];

  // The read port serves both the search and the move-to-front source.
  assign rd_data_o = ent_q[idx_i];

  always_ff @(posedge clk_i) begin
    if (op_i.shift) begin
      ent_q[0] <= op_i.take_new ? new_id_i : ent_q[idx_i];
    end
  end

  // Entries in front of the index step back by one place.
  for (genvar i = 1; i < DEPTH; i++) begin : g_ent
    always_ff @(posedge clk_i) begin
      if (op_i.shift && (idx_i >= IDX_W'(i))) begin
        ent_q[i] <= ent_q[i-1];
      end
    end
  end

endmodule : tcl_mru_list
`default_nettype wire

/* hw/rtl/target_change_limiter_core.sv */
`default_nettype none
// Sequence: a send that misses searches the target list, then the reply list, then ages
//   the target list and decides on the new target before its result is handed out;
//   hits and reply words finish sooner, as they skip some of these steps.
// Throughput: one word at a time; the search comparator and the aging subtractor
//   each handle one entry or one period per cycle. Reset clears counts, aging time
//   and registers to defaults; list entries are written before they are read.
// ----------------------------------------------------------------------------
// Target change limiter core
// Limits how fast one sender turns to new targets, using two recent-id lists.
// ----------------------------------------------------------------------------
module target_change_limiter_core #(
  parameter int unsigned TARGET_DEPTH = tcl_pkg::TARGET_DEPTH_DEF,
  parameter int unsigned REPLY_DEPTH  = tcl_pkg::REPLY_DEPTH_DEF,
  parameter int unsigned ID_WIDTH     = tcl_pkg::ID_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tcl_in_if.sink                              in_if,
  tcl_out_if.source                           out_if
);
  import tcl_pkg::*;

  localparam int unsigned TCNT_W = $clog2(TARGET_DEPTH + 1);
  localparam int unsigned RCNT_W = $clog2(REPLY_DEPTH + 1);
  localparam int unsigned TIDX_W = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
  localparam int unsigned RIDX_W = (REPLY_DEPTH > 1) ? $clog2(REPLY_DEPTH) : 1;
  localparam int unsigned SCN_W  = (TCNT_W > RCNT_W) ? TCNT_W : RCNT_W;
  localparam int unsigned TCMP_W = (TCNT_W > MT_W) ? TCNT_W : MT_W;
  localparam int unsigned RCMP_W = (RCNT_W > MR_W) ? RCNT_W : MR_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN_T = 3'd1;
  localparam logic [2:0] S_SCAN_R = 3'd2;
  localparam logic [2:0] S_AGE0   = 3'd3;
  localparam logic [2:0] S_AGE    = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [SCN_W-1:0]       ptr_q, ptr_d;
  logic [TCNT_W-1:0]      t_count_q, t_count_d;
  logic [RCNT_W-1:0]      r_count_q, r_count_d;
  logic [RCNT_W-1:0]      r_count_m1;
  logic [FIELD_NOW_W-1:0] last_q, last_d;
  logic [MT_W-1:0]        max_targets_q;
  logic [MR_W-1:0]        max_replies_q;
  logic [MR_W-1:0]        r_lim;
  logic                   out_valid_q, out_valid_d;
  logic                   out_allowed_q, out_allowed_d;

  // Payload registers of the word in progress.
  logic                   kind_q, kind_d;
  logic [ID_WIDTH-1:0]    id_q, id_d;
  logic [FIELD_NOW_W-1:0] now_q, now_d;
  logic [FIELD_NOW_W-1:0] rem_q, rem_d;
  logic                   first_q, first_d;
  logic                   res_q, res_d;

  logic [ID_WIDTH+FIELD_ID_W-1:0] id_ext;
  logic                   in_fire;
  logic                   out_free;
  logic                   t_full, r_full;
  logic                   id_hit;
  logic [ID_WIDTH-1:0]    cmp_a;
  logic [FIELD_NOW_W-1:0] sub_a, sub_b, sub_diff;
  logic                   sub_borrow;

  tcl_op_t                t_op, r_op;
  logic [TIDX_W-1:0]      t_idx;
  logic [RIDX_W-1:0]      r_idx;
  logic [ID_WIDTH-1:0]    t_rd, r_rd;

  // ---------------------------------------------------------------------------
  // List stores. Only the first count entries of each list are ever read.
  // ---------------------------------------------------------------------------
  tcl_mru_list #(
    .DEPTH (TARGET_DEPTH),
    .ID_W  (ID_WIDTH)
  ) u_target_list (
    .clk_i     (clk_i),
    .op_i      (t_op),
    .idx_i     (t_idx),
    .new_id_i  (id_q),
    .rd_data_o (t_rd)
  );

  tcl_mru_list #(
    .DEPTH (REPLY_DEPTH),
    .ID_W  (ID_WIDTH)
  ) u_reply_list (
    .clk_i     (clk_i),
    .op_i      (r_op),
    .idx_i     (r_idx),
    .new_id_i  (id_q),
    .rd_data_o (r_rd)
  );

  // ---------------------------------------------------------------------------
  // Shared units: one id comparator for both searches, and one 32-bit
  // subtractor that first forms the elapsed time and then counts off
  // whole aging periods from it.
  // ---------------------------------------------------------------------------
  assign cmp_a  = (state_q == S_SCAN_T) ? t_rd : r_rd;
  assign id_hit = (cmp_a == id_q);

  assign sub_a = (state_q == S_AGE0) ? now_q  : rem_q;
  assign sub_b = (state_q == S_AGE0) ? last_q : AGING_PERIOD;
  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

  // The target list is full at the configured limit or at its depth.
  assign t_full = (TCMP_W'(t_count_q) >= TCMP_W'(max_targets_q)) ||
                  (t_count_q == TCNT_W'(TARGET_DEPTH));

  // A reply limit of zero behaves as one.
  assign r_lim  = (max_replies_q == '0) ? MR_W'(1) : max_replies_q;
  assign r_full = (RCMP_W'(r_count_q) >= RCMP_W'(r_lim)) ||
                  (r_count_q == RCNT_W'(REPLY_DEPTH));
  assign r_count_m1 = r_count_q - 1'b1;

  // Ids wider than the stored width are cut, narrower ones zero-extended.
  assign id_ext = {{ID_WIDTH{1'b0}}, in_if.target_id};

  assign in_if.ready    = (state_q == S_IDLE);
  assign in_fire        = in_if.valid && in_if.ready;
  assign out_free       = !out_valid_q || out_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.allowed = out_allowed_q;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    t_count_d     = t_count_q;
    r_count_d     = r_count_q;
    last_d        = last_q;
    kind_d        = kind_q;
    id_d          = id_q;
    now_d         = now_q;
    rem_d         = rem_q;
    first_d       = first_q;
    res_d         = res_q;
    t_op          = '0;
    r_op          = '0;
    t_idx         = ptr_q[TIDX_W-1:0];
    r_idx         = ptr_q[RIDX_W-1:0];
    out_valid_d   = (out_valid_q && out_if.ready) ? 1'b0 : out_valid_q;
    out_allowed_d = out_allowed_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          kind_d  = in_if.kind;
          id_d    = id_ext[ID_WIDTH-1:0];
          now_d   = in_if.now_seconds;
          ptr_d   = '0;
          state_d = (in_if.kind == KIND_REPLY) ? S_SCAN_R : S_SCAN_T;
        end
      end

      // Search the target list one entry a cycle; a hit moves it to the front.
      S_SCAN_T: begin
        if (ptr_q == SCN_W'(t_count_q)) begin
          ptr_d   = '0;
          state_d = S_SCAN_R;
        end else if (id_hit) begin
          t_op.shift = 1'b1;
          res_d      = 1'b1;
          state_d    = S_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Search the reply list. A reply that misses is pushed here, dropping
      // the oldest entry when the list is full.
      S_SCAN_R: begin
        if (ptr_q == SCN_W'(r_count_q)) begin
          if (kind_q == KIND_REPLY) begin
            r_op.shift    = 1'b1;
            r_op.take_new = 1'b1;
            if (r_full) begin
              r_idx = r_count_m1[RIDX_W-1:0];
            end else begin
              r_idx     = r_count_q[RIDX_W-1:0];
              r_count_d = r_count_q + 1'b1;
            end
            res_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_AGE0;
          end
        end else if (id_hit) begin
          r_op.shift = 1'b1;
          res_d      = 1'b1;
          state_d    = S_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Elapsed time since the last aging; time going backwards ages nothing.
      S_AGE0: begin
        rem_d   = sub_borrow ? '0 : sub_diff;
        first_d = 1'b1;
        state_d = S_AGE;
      end

      // One whole period per cycle drops one oldest target. The aging time
      // moves only when at least one whole period has gone by.
      S_AGE: begin
        first_d = 1'b0;
        if (!sub_borrow) begin
          if (first_q) begin
            last_d = now_q;
          end
          if (t_count_q != '0) begin
            rem_d     = sub_diff;
            t_count_d = t_count_q - 1'b1;
          end else begin
            state_d = S_DECIDE;
          end
        end else begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (t_full) begin
          res_d = 1'b0;
        end else begin
          t_op.shift    = 1'b1;
          t_op.take_new = 1'b1;
          t_idx         = t_count_q[TIDX_W-1:0];
          t_count_d     = t_count_q + 1'b1;
          res_d         = 1'b1;
        end
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_allowed_d = res_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      t_count_q   <= '0;
      r_count_q   <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      t_count_q   <= t_count_d;
      r_count_q   <= r_count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers, unguarded; user writes only while no word is in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_targets_q <= MAX_TARGETS_RST;
      max_replies_q <= MAX_REPLIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_TARGETS: max_targets_q <= cfg_data_i[MT_W-1:0];
        CFG_MAX_REPLIES: max_replies_q <= cfg_data_i[MR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    id_q          <= id_d;
    now_q         <= now_d;
    rem_q         <= rem_d;
    first_q       <= first_d;
    res_q         <= res_d;
    out_allowed_q <= out_allowed_d;
  end

endmodule : target_change_limiter_core
`default_nettype wire

/* hw/rtl/tcl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Target change limiter checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module tcl_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_allowed_i
);

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_allowed_i)))
    else $error("result word changed while stalled");

  // An accepted word keeps the core busy, so ready stays low after it is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> (!in_ready_i ##1 !in_ready_i))
    else $error("input accepted again too early");

  // A new result only appears at the end of work on a word.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while the core was idle");

endmodule : tcl_checker

bind target_change_limiter_core tcl_checker u_tcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_allowed_i (out_if.allowed)
);
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Target change limiter testbench
// Drives send and reply words into the core, predicts each allowed flag with
// a behavioral copy of the two recent-id lists, and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import tcl_pkg::*;

  // The core handles one word at a time, and both sides stall at
  // random. A watchdog that sees this many cycles without any word moving on
  // either channel declares the run hung.
  localparam int unsigned HANG_LIMIT   = 4000;
  // Cycles to keep watching after the last expected word has arrived.
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_WORDS  = 230;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned TGT_DEPTH    = TARGET_DEPTH_DEF;
  localparam int unsigned REP_DEPTH    = REPLY_DEPTH_DEF;

  // Register settings of the random phases. The last phase draws its own.
  localparam int unsigned PH_MAX_TARGETS [PHASES] = '{3, 16, 0, 31, 1, 10};
  localparam int unsigned PH_MAX_REPLIES [PHASES] = '{2, 8, 1, 15, 0, 5};

  // One row of the directed table. Where typed is set, the expected flag is
  // taken from the row; otherwise the predictor supplies it.
  typedef struct {
    logic        kind;
    logic [31:0] id;
    logic [31:0] now;
    bit          typed;
    logic        allowed;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcl_in_if  in_ch ();
  tcl_out_if out_ch ();

  target_change_limiter_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: the two lists are kept front first, so index 0 is the
  // most recently used id. Register copies follow every write.
  logic [31:0]     tgt_mru [$];
  logic [31:0]     rep_mru [$];
  logic [31:0]     last_age_s;
  logic [MT_W-1:0] max_targets_r;
  logic [MR_W-1:0] max_replies_r;

  // Expected allowed flags, oldest first.
  logic pending_allowed [$];

  // Side information for the word now on the input channel. It is set at the
  // falling edge together with the payload, so the monitor reads it stable.
  bit   row_typed;
  logic row_allowed;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  logic        exp_allowed;
  logic        got_pred;

  dir_row_t    dir_rows [DIR_ROWS];
  logic [31:0] id_pool [POOL_SIZE];
  logic [31:0] now_cur;

  // Works out the allowed flag of one word and updates the lists the way the
  // core should.
  function automatic logic predict_allowed(input logic kind, input logic [31:0] id,
                                           input logic [31:0] now);
    int          pos_t;
    int          pos_r;
    int unsigned lim;
    logic [31:0] periods;
    pos_t = -1;
    pos_r = -1;
    foreach (tgt_mru[i]) if (pos_t < 0 && tgt_mru[i] == id) pos_t = i;
    foreach (rep_mru[i]) if (pos_r < 0 && rep_mru[i] == id) pos_r = i;

    if (kind == KIND_REPLY) begin
      // A zero capacity behaves as one, and anything past the depth as the depth.
      lim = (max_replies_r == 0) ? 1 : max_replies_r;
      if (lim > REP_DEPTH) lim = REP_DEPTH;
      if (pos_r >= 0) begin
        rep_mru.delete(pos_r);
      end else if (rep_mru.size() >= lim) begin
        // Only one entry goes, even when the capacity was lowered below the fill.
        rep_mru.delete(rep_mru.size() - 1);
      end
      rep_mru.insert(0, id);
      return 1'b1;
    end

    if (pos_t >= 0) begin
      tgt_mru.delete(pos_t);
      tgt_mru.insert(0, id);
      return 1'b1;
    end
    if (pos_r >= 0) begin
      rep_mru.delete(pos_r);
      rep_mru.insert(0, id);
      return 1'b1;
    end

    // A miss ages the target list first. Time that runs backwards ages nothing.
    if (now >= last_age_s) begin
      periods = (now - last_age_s) / AGING_PERIOD;
      if (periods != 0) begin
        last_age_s = now;
        while (tgt_mru.size() != 0 && periods != 0) begin
          tgt_mru.delete(tgt_mru.size() - 1);
          periods--;
        end
      end
    end

    lim = (max_targets_r > TGT_DEPTH) ? TGT_DEPTH : max_targets_r;
    if (tgt_mru.size() >= lim) return 1'b0;
    tgt_mru.insert(0, id);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Writes one register while the core is idle and mirrors it in the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    if (idx == CFG_MAX_TARGETS) max_targets_r = value[MT_W-1:0];
    else                        max_replies_r = value[MR_W-1:0];
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  // Offers one word after a random number of idle cycles and returns at the
  // rising edge where it is taken. Valid stays high until the next decision.
  task automatic send_word(input logic kind, input logic [31:0] id, input logic [31:0] now,
                           input bit typed, input logic typed_allowed);
    @(negedge clk_i);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.kind        = kind;
    in_ch.target_id   = id;
    in_ch.now_seconds = now;
    row_typed         = typed;
    row_allowed       = typed_allowed;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  // Drops valid and waits until every word sent has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_allowed.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: ready is redrawn at every falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Monitor. The result side is handled first: a result taken at the same
  // edge as a new word always belongs to an older word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_allowed.size() == 0) begin
          report_mismatch($sformatf("result word allowed=%b with no word pending",
                                    out_ch.allowed));
        end else begin
          exp_allowed = pending_allowed.pop_front();
          if (out_ch.allowed !== exp_allowed)
            report_mismatch($sformatf("allowed=%b, expected %b", out_ch.allowed,
                                      exp_allowed));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        got_pred = predict_allowed(in_ch.kind, in_ch.target_id, in_ch.now_seconds);
        pending_allowed.push_back(row_typed ? row_allowed : got_pred);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", HANG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned r;
    int unsigned mt;
    int unsigned mr;
    logic        kind;
    logic [31:0] id;

    // Every input is known from time zero, and reset starts asserted.
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_MAX_TARGETS;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_SEND;
    in_ch.target_id   = '0;
    in_ch.now_seconds = '0;
    out_ch.ready      = 1'b0;
    row_typed         = 1'b0;
    row_allowed       = 1'b0;
    err_cnt           = 0;
    quiet_cycles      = 0;
    tx_idle_pct       = 23;
    rx_idle_pct       = 46;
    max_targets_r     = MAX_TARGETS_RST;
    max_replies_r     = MAX_REPLIES_RST;
    last_age_s        = '0;

    // Directed words, run with the reset settings (10 targets, 5 replies).
    dir_rows = '{
      // The first two sends after reset always go through, at both id extremes.
      '{KIND_SEND,  32'h0000_0000, 32'd0,   1, 1'b1},
      '{KIND_SEND,  32'hFFFF_FFFF, 32'd0,   1, 1'b1},
      // A repeat target is a hit.
      '{KIND_SEND,  32'h0000_0000, 32'd5,   0, 1'b0},
      // Reply words are always allowed; a send to a recorded sender is a hit.
      '{KIND_REPLY, 32'hA5A5_A5A5, 32'd5,   1, 1'b1},
      '{KIND_SEND,  32'hA5A5_A5A5, 32'd6,   0, 1'b0},
      // Eight new targets fill the list to its limit of ten.
      '{KIND_SEND,  32'h0000_0101, 32'd10,  0, 1'b0},
      '{KIND_SEND,  32'h0000_0102, 32'd10,  0, 1'b0},
      '{KIND_SEND,  32'h0000_0103, 32'd10,  0, 1'b0},
      '{KIND_SEND,  32'h0000_0104, 32'd10,  0, 1'b0},
      '{KIND_SEND,  32'h0000_0105, 32'd10,  0, 1'b0},
      '{KIND_SEND,  32'h0000_0106, 32'd10,  0, 1'b0},
      '{KIND_SEND,  32'h0000_0107, 32'd10,  0, 1'b0},
      '{KIND_SEND,  32'h0000_0108, 32'd10,  0, 1'b0},
      // A full list denies new targets until a whole minute has passed.
      '{KIND_SEND,  32'h5A5A_5A5A, 32'd30,  1, 1'b0},
      '{KIND_SEND,  32'h5A5A_5A5A, 32'd59,  1, 1'b0},
      '{KIND_SEND,  32'h5A5A_5A5A, 32'd60,  0, 1'b0},
      '{KIND_SEND,  32'h0000_C0DE, 32'd119, 1, 1'b0},
      // The latest possible time ages the whole list away.
      '{KIND_SEND,  32'h1234_5678, 32'hFFFF_FFFF, 1, 1'b1},
      // Time running backwards ages nothing.
      '{KIND_SEND,  32'h0000_C0DE, 32'd100, 0, 1'b0},
      // Six replies overflow the reply list, pushing the oldest senders out.
      '{KIND_REPLY, 32'h0000_0201, 32'd100, 1, 1'b1},
      '{KIND_REPLY, 32'h0000_0202, 32'd100, 1, 1'b1},
      '{KIND_REPLY, 32'h0000_0203, 32'd100, 1, 1'b1},
      '{KIND_REPLY, 32'h0000_0204, 32'd100, 1, 1'b1},
      '{KIND_REPLY, 32'h0000_0205, 32'd100, 1, 1'b1},
      '{KIND_REPLY, 32'h0000_0206, 32'd100, 1, 1'b1},
      '{KIND_SEND,  32'h0000_0201, 32'd100, 0, 1'b0}
    };

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[k])
      send_word(dir_rows[k].kind, dir_rows[k].id, dir_rows[k].now,
                dir_rows[k].typed, dir_rows[k].allowed);
    wait_drained();

    // Random phases. Each one starts from an idle core with new register
    // values; the lists carry over, so lowered limits meet fuller lists.
    // Two phases each: sender idles less than receiver, the reverse, none.
    now_cur = 32'd200;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0:       begin tx_idle_pct = 23; rx_idle_pct = 46; end
        1:       begin tx_idle_pct = 46; rx_idle_pct = 23; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      mt = (ph == PHASES - 1) ? $urandom_range(0, 31) : PH_MAX_TARGETS[ph];
      mr = (ph == PHASES - 1) ? $urandom_range(0, 15) : PH_MAX_REPLIES[ph];
      write_reg(CFG_MAX_TARGETS, mt);
      write_reg(CFG_MAX_REPLIES, mr);

      // A small pool of ids, a little larger than the target list, gives
      // plenty of hits, misses and evictions.
      foreach (id_pool[k]) id_pool[k] = $urandom();

      for (n = 0; n < PHASE_WORDS; n++) begin
        // Time mostly creeps forward, sometimes jumps further ahead,
        // now and then steps back, and rarely lands anywhere at all.
        r = $urandom_range(0, 99);
        if (r < 70)      now_cur = now_cur + $urandom_range(0, 15);
        else if (r < 90) now_cur = now_cur + $urandom_range(16, 400);
        else if (r < 95) now_cur = now_cur;
        else if (r < 98) now_cur = now_cur - $urandom_range(1, 200);
        else             now_cur = $urandom();

        kind = ($urandom_range(0, 99) < 30) ? KIND_REPLY : KIND_SEND;
        id   = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom();
        send_word(kind, id, now_cur, 1'b0, 1'b0);
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : testbench

/* sim.f */
hw/rtl/tcl_pkg.sv
hw/rtl/tcl_if.sv
hw/rtl/tcl_mru_list.sv
hw/rtl/target_change_limiter_core.sv
hw/rtl/tcl_checker.sv
tb/sv/testbench.sv
